// File: hdl/ptcd_pkg.sv
// Package for the CHS partition table decoder: shared types, register
// indexes, status codes and fixed constants. No dependencies.
`timescale 1ns / 1ps

package ptcd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_HEADS      = 3'd0;
  localparam logic [2:0] REG_SECTORS    = 3'd1;
  localparam logic [2:0] REG_CAPACITY   = 3'd2;
  localparam logic [2:0] REG_SLOT_LIMIT = 3'd3;
  localparam logic [2:0] REG_BOOT_SIG   = 3'd4;
  localparam logic [2:0] REG_BLOCK_SIZE = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [8:0]  HEADS_RESET      = 9'd8;
  localparam logic [8:0]  SECTORS_RESET    = 9'd17;
  localparam logic [47:0] CAPACITY_RESET   = 48'd0;
  localparam logic [8:0]  SLOT_LIMIT_RESET = 9'd256;
  localparam logic [15:0] BOOT_SIG_RESET   = 16'd0;
  localparam logic [15:0] BLOCK_SIZE_RESET = 16'd512;

  localparam logic [15:0] SIG_WORD    = 16'haa55;
  localparam logic [15:0] BLOCK_BYTES = 16'd512;
  localparam logic [8:0]  GEOM_MAX    = 9'd256;

  // Depth of the queue between the front and back ends.
  localparam int QDEPTH = 2;
  localparam int QPW    = 1;

  typedef enum logic [2:0] {
    KIND_PARTITION = 3'd0,
    KIND_ACCEPTED  = 3'd1,
    KIND_NONE      = 3'd2,
    KIND_BAD_BLOCK = 3'd3,
    KIND_NO_SIG    = 3'd4,
    KIND_INVALID   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [8:0]  heads;
    logic [8:0]  sectors;
    logic [47:0] capacity;
    logic [8:0]  slot_limit;
    logic [15:0] boot_signature;
    logic [15:0] logical_block_size;
  } ptcd_cfg_t;

  // One classified entry, as the front end hands it to the back end.
  typedef struct packed {
    logic        used;
    logic        bad;
    logic [31:0] start_lba;
    logic [31:0] end_lba;
  } ptcd_cmd_t;

endpackage

// File: hdl/partition_table_chs_decoder.sv
// CHS partition table decoder top level. The front end takes one entry at a time
// (accept, two multiply stages, queue push), holding off the next until the push is
// taken. After the last entry the back end emits the status of a rejected table,
// or scans the slots, emits the partitions found, then the status; stalls can hold it.
// Reset is synchronous: configuration returns to defaults and table state clears;
// the entry store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module partition_table_chs_decoder import ptcd_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  media_id,
  input  logic [7:0]  system_id,
  input  logic [15:0] reserved_word,
  input  logic [7:0]  loader_sector,
  input  logic [7:0]  boot_head,
  input  logic [7:0]  first_sector,
  input  logic [7:0]  first_head,
  input  logic [15:0] first_cylinder,
  input  logic [7:0]  final_sector,
  input  logic [7:0]  final_head,
  input  logic [15:0] final_cylinder,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [4:0]  slot,
  output logic [31:0] start_lba,
  output logic [32:0] sector_count,
  output logic        last
);

  ptcd_cfg_t cfg;
  logic      push_valid;
  logic      push_ready;
  ptcd_cmd_t push_cmd;
  logic      pop_valid;
  logic      pop_ready;
  ptcd_cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heads              <= HEADS_RESET;
      cfg.sectors            <= SECTORS_RESET;
      cfg.capacity           <= CAPACITY_RESET;
      cfg.slot_limit         <= SLOT_LIMIT_RESET;
      cfg.boot_signature     <= BOOT_SIG_RESET;
      cfg.logical_block_size <= BLOCK_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEADS:      cfg.heads              <= cfg_data[8:0];
        REG_SECTORS:    cfg.sectors            <= cfg_data[8:0];
        REG_CAPACITY:   cfg.capacity           <= cfg_data;
        REG_SLOT_LIMIT: cfg.slot_limit         <= cfg_data[8:0];
        REG_BOOT_SIG:   cfg.boot_signature     <= cfg_data[15:0];
        REG_BLOCK_SIZE: cfg.logical_block_size <= cfg_data[15:0];
        default:        cfg                    <= cfg;
      endcase
    end
  end

  ptcd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .media_id       (media_id),
    .system_id      (system_id),
    .reserved_word  (reserved_word),
    .loader_sector  (loader_sector),
    .boot_head      (boot_head),
    .first_sector   (first_sector),
    .first_head     (first_head),
    .first_cylinder (first_cylinder),
    .final_sector   (final_sector),
    .final_head     (final_head),
    .final_cylinder (final_cylinder),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd)
  );

  ptcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  ptcd_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_cmd      (pop_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .slot         (slot),
    .start_lba    (start_lba),
    .sector_count (sector_count),
    .last         (last)
  );

endmodule

// File: hdl/ptcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptcd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/ptcd_front.sv
// Front end: accepts one table entry, checks it against the geometry and
// converts its start and end to LBA. Depends on ptcd_pkg.
`timescale 1ns / 1ps

module ptcd_front import ptcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ptcd_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  media_id,
  input  logic [7:0]  system_id,
  input  logic [15:0] reserved_word,
  input  logic [7:0]  loader_sector,
  input  logic [7:0]  boot_head,
  input  logic [7:0]  first_sector,
  input  logic [7:0]  first_head,
  input  logic [15:0] first_cylinder,
  input  logic [7:0]  final_sector,
  input  logic [7:0]  final_head,
  input  logic [15:0] final_cylinder,
  output logic        push_valid,
  input  logic        push_ready,
  output ptcd_cmd_t   push_cmd
);

  typedef enum logic [1:0] {F_IDLE, F_MUL1, F_MUL2, F_PUSH} fstate_t;

  fstate_t     state;
  logic [8:0]  h;
  logic [8:0]  s;
  logic        used_in;
  logic        bad_in;
  logic        used;
  logic        bad;
  logic [15:0] fc;
  logic [15:0] ec;
  logic [7:0]  fh;
  logic [7:0]  eh;
  logic [7:0]  fs;
  logic [7:0]  es;
  logic [25:0] pf;
  logic [25:0] pe;
  logic [25:0] pf_next;
  logic [25:0] pe_next;
  logic [24:0] mf;
  logic [24:0] me;
  logic [34:0] wf;
  logic [34:0] we;
  logic [31:0] lba_f;
  logic [31:0] lba_e;

  // Geometry above 256 behaves as 256; heads and sectors are at most 255.
  assign h = (cfg.heads > GEOM_MAX) ? GEOM_MAX : cfg.heads;
  assign s = (cfg.sectors > GEOM_MAX) ? GEOM_MAX : cfg.sectors;

  assign used_in = (media_id != 8'd0) || (system_id != 8'd0);
  assign bad_in  = used_in &&
                   ((media_id == 8'd0) || (system_id == 8'd0) ||
                    (reserved_word != 16'd0) || (first_cylinder > final_cylinder) ||
                    ({1'b0, boot_head} >= h) || ({1'b0, loader_sector} >= s) ||
                    ({1'b0, first_head} >= h) || ({1'b0, first_sector} >= s) ||
                    ({1'b0, final_head} >= h) || ({1'b0, final_sector} >= s));

  always_comb begin
    mf      = {9'd0, fc} * {16'd0, h};
    me      = {9'd0, ec} * {16'd0, h};
    pf_next = {1'b0, mf} + {18'd0, fh};
    pe_next = {1'b0, me} + {18'd0, eh};
    wf      = {9'd0, pf} * {26'd0, s};
    we      = {9'd0, pe} * {26'd0, s};
  end

  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_cmd   = '{used: used, bad: bad, start_lba: lba_f, end_lba: lba_e};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            used  <= used_in;
            bad   <= bad_in;
            fc    <= first_cylinder;
            fh    <= first_head;
            fs    <= first_sector;
            ec    <= final_cylinder;
            eh    <= final_head;
            es    <= final_sector;
            state <= F_MUL1;
          end
        end
        F_MUL1: begin
          pf    <= pf_next;
          pe    <= pe_next;
          state <= F_MUL2;
        end
        F_MUL2: begin
          lba_f <= wf[31:0] + {24'd0, fs};
          lba_e <= we[31:0] + {24'd0, es};
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/ptcd_queue.sv
// Two-entry queue of classified entries between the front and back ends.
// Depends on ptcd_pkg.
`timescale 1ns / 1ps

module ptcd_queue import ptcd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  ptcd_cmd_t push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output ptcd_cmd_t pop_cmd
);

  ptcd_cmd_t        slots [QDEPTH];
  logic [QPW-1:0]   wp;
  logic [QPW-1:0]   rp;
  logic [QPW:0]     cnt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt != (QPW + 1)'(QDEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_cmd    = slots[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// File: hdl/ptcd_back.sv
// Back end: keeps the table state, stores entry LBAs, gives the verdict and
// walks the stored slots to emit partitions. Depends on ptcd_pkg, ptcd_ram.
`timescale 1ns / 1ps

module ptcd_back import ptcd_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  ptcd_cfg_t   cfg,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  ptcd_cmd_t   pop_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [4:0]  slot,
  output logic [31:0] start_lba,
  output logic [32:0] sector_count,
  output logic        last
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW = (IW + 1 > 5) ? IW + 1 : 5;

  typedef enum logic [2:0] {
    B_IDLE, B_DECIDE, B_SCAN, B_READ, B_EMIT, B_STATUS
  } bstate_t;

  bstate_t      state;
  logic [IW-1:0] idx;
  logic         table_bad;
  logic         any_used;
  logic [ENTRIES-1:0] used_mask;
  logic [IW:0]  kc;
  logic [IW:0]  kc_inc;
  logic         found;
  kind_t        st_kind;
  logic         skip;
  logic [31:0]  s_r;
  logic [31:0]  e_r;
  logic         out_free;
  logic         out_load;
  logic         take;
  logic         scan_more;
  logic [SW-1:0] slot_wide;
  logic         wr_en;
  logic         rd_en;
  logic [63:0]  rd_data;
  logic [31:0]  rd_s;
  logic [31:0]  rd_e;

  assign pop_ready = (state == B_IDLE);
  assign take      = pop_valid && pop_ready;
  assign wr_en     = take && pop_cmd.used && !pop_cmd.bad;
  assign out_free  = !out_valid || out_ready;
  // The output register is loaded by a partition or by the closing status.
  assign out_load  = out_free && (((state == B_EMIT) && !skip) || (state == B_STATUS));
  assign kc_inc    = kc + 1'b1;
  assign slot_wide = SW'(kc_inc);
  // A slot is looked at only below the entry count and the slot limit.
  assign scan_more = (kc < (IW + 1)'(ENTRIES)) &&
                     ({{(10 - (IW + 1)){1'b0}}, kc_inc} < {1'b0, cfg.slot_limit});
  assign rd_en     = (state == B_SCAN) && scan_more && used_mask[kc[IW-1:0]];
  assign rd_s      = rd_data[63:32];
  assign rd_e      = rd_data[31:0];

  ptcd_ram #(
    .WIDTH (64),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data ({pop_cmd.start_lba, pop_cmd.end_lba}),
    .rd_en   (rd_en),
    .rd_addr (kc[IW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      idx       <= '0;
      table_bad <= 1'b0;
      any_used  <= 1'b0;
      used_mask <= '0;
      kc        <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (take) begin
            if (pop_cmd.bad) begin
              table_bad <= 1'b1;
            end else if (pop_cmd.used) begin
              any_used       <= 1'b1;
              used_mask[idx] <= 1'b1;
            end
            if (idx == IW'(ENTRIES - 1)) begin
              idx   <= '0;
              state <= B_DECIDE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        B_DECIDE: begin
          kc    <= '0;
          found <= 1'b0;
          if (cfg.logical_block_size != BLOCK_BYTES) begin
            st_kind <= KIND_BAD_BLOCK;
            state   <= B_STATUS;
          end else if (cfg.boot_signature != SIG_WORD) begin
            st_kind <= KIND_NO_SIG;
            state   <= B_STATUS;
          end else if (table_bad) begin
            st_kind <= KIND_INVALID;
            state   <= B_STATUS;
          end else if (!any_used) begin
            st_kind <= KIND_NONE;
            state   <= B_STATUS;
          end else begin
            state <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (!scan_more) begin
            st_kind <= found ? KIND_ACCEPTED : KIND_NONE;
            state   <= B_STATUS;
          end else if (rd_en) begin
            state <= B_READ;
          end else begin
            kc <= kc_inc;
          end
        end
        B_READ: begin
          // A clamped end is below a capacity that fits in 32 bits.
          skip  <= (rd_e < rd_s) || ({16'd0, rd_s} >= cfg.capacity);
          s_r   <= rd_s;
          e_r   <= ({16'd0, rd_e} >= cfg.capacity) ? (cfg.capacity[31:0] - 32'd1) : rd_e;
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (skip) begin
            kc    <= kc_inc;
            state <= B_SCAN;
          end else if (out_free) begin
            kind         <= KIND_PARTITION;
            slot         <= slot_wide[4:0];
            start_lba    <= s_r;
            sector_count <= {1'b0, e_r} - {1'b0, s_r} + 33'd1;
            last         <= 1'b0;
            found        <= 1'b1;
            kc           <= kc_inc;
            state        <= B_SCAN;
          end
        end
        B_STATUS: begin
          if (out_free) begin
            kind         <= st_kind;
            slot         <= 5'd0;
            start_lba    <= 32'd0;
            sector_count <= 33'd0;
            last         <= 1'b1;
            table_bad    <= 1'b0;
            any_used     <= 1'b0;
            used_mask    <= '0;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
